[design/lcs_pkg.sv]
// Shared constants, types and the arctangent table of the law-of-cosines solver.
// Used by the channel interfaces, the CORDIC and square-root pipelines and the top level.
package lcs_pkg;

  localparam int SideW = 24;
  localparam int AngW  = 16;
  localparam int AnsW  = 25;
  localparam int StatW = 2;
  localparam int IdxW  = 2;

  localparam int TrigIterations = 16;

  localparam int CordW = 36;
  localparam int SqW   = 62;

  localparam logic signed [CordW-1:0] OneQ30    = 36'sd1073741824;
  localparam logic signed [CordW-1:0] NegOneQ30 = -36'sd1073741824;
  localparam logic signed [CordW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30   = 36'sd652032874;

  localparam logic [24:0] DegToRad = 25'd18740330;
  localparam logic [29:0] RadToDeg = 30'd961263669;
  localparam logic [AngW-1:0] Deg180 = 16'd46080;

  typedef enum logic [StatW-1:0] {
    STATUS_SIDE  = 2'd0,
    STATUS_ANGLE = 2'd1,
    STATUS_NOFIT = 2'd2,
    STATUS_NOTRI = 2'd3
  } status_e;

  function automatic logic signed [CordW-1:0] atan_q30(input int unsigned i);
    logic signed [CordW-1:0] v;
    case (i)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048576;
      11: v = 36'sd524288;
      12: v = 36'sd262144;
      13: v = 36'sd131072;
      14: v = 36'sd65536;
      15: v = 36'sd32768;
      16: v = 36'sd16384;
      17: v = 36'sd8192;
      18: v = 36'sd4096;
      19: v = 36'sd2048;
      20: v = 36'sd1024;
      21: v = 36'sd512;
      22: v = 36'sd256;
      23: v = 36'sd128;
      24: v = 36'sd64;
      25: v = 36'sd32;
      26: v = 36'sd16;
      27: v = 36'sd8;
      28: v = 36'sd4;
      29: v = 36'sd2;
      30: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/lcs_if.sv]
// Valid/ready channel interfaces for triangle requests and solved results.
// Depends on lcs_pkg for the field widths.
interface lcs_in_if import lcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SideW-1:0] side_a;
  logic [SideW-1:0] side_b;
  logic [SideW-1:0] side_c;
  logic [AngW-1:0]  angle_a;
  logic [AngW-1:0]  angle_b;
  logic [AngW-1:0]  angle_c;

  modport source (output valid, side_a, side_b, side_c, angle_a, angle_b, angle_c,
                  input ready);
  modport sink (input valid, side_a, side_b, side_c, angle_a, angle_b, angle_c,
                output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AnsW-1:0]  answer;
  logic [StatW-1:0] status;
  logic [IdxW-1:0]  solved_index;

  modport source (output valid, answer, status, solved_index, input ready);
  modport sink (input valid, answer, status, solved_index, output ready);
endinterface

[design/lcs_isqrt.sv]
// Pipelined floor square root, one result bit per register stage, with a side tag.
// Depends on lcs_pkg.
module lcs_isqrt import lcs_pkg::*; #(
  parameter int InW  = SqW,
  parameter int TagW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [InW-1:0]    rad_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [InW/2-1:0]  root_o,
  output logic [TagW-1:0]   tag_o
);

  localparam int Steps = InW / 2;
  localparam int RootW = Steps;
  localparam int RemW  = Steps + 2;

  logic             v_q    [Steps];
  logic [InW-1:0]   val_q  [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [RootW-1:0] root_q [Steps];
  logic [TagW-1:0]  tag_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic             v_in;
    logic [InW-1:0]   val_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [TagW-1:0]  tag_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign val_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], val_in[InW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k]  <= {val_in[InW-3:0], 2'b00};
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RootW-2:0], take};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule

[design/lcs_cordic.sv]
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on lcs_pkg for the word width and the arctangent table.
module lcs_cordic import lcs_pkg::*; #(
  parameter int Iter      = TrigIterations,
  parameter bit Vectoring = 1'b0,
  parameter int TagW      = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [CordW-1:0] x_i,
  input  logic signed [CordW-1:0] y_i,
  input  logic signed [CordW-1:0] z_i,
  input  logic [TagW-1:0]         tag_i,
  output logic                    valid_o,
  output logic signed [CordW-1:0] x_o,
  output logic signed [CordW-1:0] y_o,
  output logic signed [CordW-1:0] z_o,
  output logic [TagW-1:0]         tag_o
);

  logic                    v_q   [Iter];
  logic signed [CordW-1:0] x_q   [Iter];
  logic signed [CordW-1:0] y_q   [Iter];
  logic signed [CordW-1:0] z_q   [Iter];
  logic [TagW-1:0]         tag_q [Iter];

  for (genvar k = 0; k < Iter; k++) begin : g_stage
    logic                    v_in;
    logic signed [CordW-1:0] x_in, y_in, z_in;
    logic signed [CordW-1:0] dx, dy;
    logic signed [CordW-1:0] x_d, y_d, z_d;
    logic [TagW-1:0]         tag_in;
    logic                    sigma;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
      assign z_in   = z_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign dx    = y_in >>> k;
    assign dy    = x_in >>> k;
    assign sigma = Vectoring ? (y_in[CordW-1] || (y_in == '0)) : !z_in[CordW-1];

    always_comb begin
      if (sigma) begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - atan_q30(k);
      end else begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= x_d;
        y_q[k]   <= y_d;
        z_q[k]   <= z_d;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[Iter-1];
  assign x_o     = x_q[Iter-1];
  assign y_o     = y_q[Iter-1];
  assign z_o     = z_q[Iter-1];
  assign tag_o   = tag_q[Iter-1];

endmodule

[design/law_of_cosines_solver.sv]
// Law-of-cosines triangle solver: top level, case selection, divider and output stages.
// Depends on lcs_pkg, lcs_if, lcs_cordic and lcs_isqrt.
//
//   port    dir  handshake      payload
//   req_i   in   valid/ready    side_a, side_b, side_c, angle_a, angle_b, angle_c
//   rsp_o   out  valid/ready    answer, status, solved_index
//
// One triangle enters per cycle while the output is not stalled; the path runs through two
// CORDIC pipelines, the 30-stage divider and the 31-stage square root.
// All stages advance together whenever the output register is empty or being taken.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits only.
module law_of_cosines_solver import lcs_pkg::*; #(
  parameter int TrigIter = TrigIterations
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcs_in_if.sink    req_i,
  lcs_out_if.source rsp_o
);

  localparam int Iter    = (TrigIter > 32) ? 32 : TrigIter;
  localparam int SqrW    = 2 * SideW;
  localparam int SumW    = SqrW + 1;
  localparam int RadW    = 33;
  localparam int QFrac   = 30;
  localparam int RootW   = SqW / 2;
  localparam int SradW   = SumW + 2;

  typedef enum logic [1:0] {KIND_SIDE, KIND_ANGLE, KIND_NONE} kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] idx;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [SumW-1:0] s;
    logic [SumW-1:0] d;
    logic [SqrW-1:0] zz;
    logic            cneg;
  } rot_t;

  typedef struct packed {
    meta_t            meta;
    logic             neg;
    logic             bad;
    logic             eq;
    logic [SradW-1:0] srad;
  } div_t;

  typedef struct packed {
    meta_t        meta;
    logic         neg;
    logic         bad;
    logic [QFrac:0] q;
  } sq_t;

  typedef struct packed {
    meta_t           meta;
    logic            bad;
    logic [AnsW-1:0] ans;
  } vec_t;

  logic adv;
  logic out_v_q;

  assign adv         = !out_v_q || rsp_o.ready;
  assign req_i.ready = adv;

  // case selection
  meta_t            sel_meta;
  logic [SideW-1:0] sel_x, sel_y, sel_z;
  logic [AngW-1:0]  sel_deg;
  logic             a_nz, b_nz, c_nz;

  assign a_nz = req_i.side_a != '0;
  assign b_nz = req_i.side_b != '0;
  assign c_nz = req_i.side_c != '0;

  always_comb begin
    sel_meta.kind = KIND_NONE;
    sel_meta.idx  = '0;
    sel_x         = '0;
    sel_y         = '0;
    sel_z         = '0;
    sel_deg       = '0;
    if (!a_nz && b_nz && c_nz && req_i.angle_a != '0) begin
      sel_meta.kind = KIND_SIDE;
      sel_x         = req_i.side_b;
      sel_y         = req_i.side_c;
      sel_deg       = req_i.angle_a;
    end else if (!b_nz && a_nz && c_nz && req_i.angle_b != '0) begin
      sel_meta.kind = KIND_SIDE;
      sel_meta.idx  = 2'd1;
      sel_x         = req_i.side_a;
      sel_y         = req_i.side_c;
      sel_deg       = req_i.angle_b;
    end else if (!c_nz && a_nz && b_nz && req_i.angle_c != '0) begin
      sel_meta.kind = KIND_SIDE;
      sel_meta.idx  = 2'd2;
      sel_x         = req_i.side_a;
      sel_y         = req_i.side_b;
      sel_deg       = req_i.angle_c;
    end else if (a_nz && b_nz && c_nz &&
                 (req_i.angle_a == '0 || req_i.angle_b == '0 || req_i.angle_c == '0)) begin
      sel_meta.kind = KIND_ANGLE;
      if (req_i.angle_a == '0) begin
        sel_x = req_i.side_b;
        sel_y = req_i.side_c;
        sel_z = req_i.side_a;
      end else if (req_i.angle_b == '0) begin
        sel_meta.idx = 2'd1;
        sel_x        = req_i.side_c;
        sel_y        = req_i.side_a;
        sel_z        = req_i.side_b;
      end else begin
        sel_meta.idx = 2'd2;
        sel_x        = req_i.side_a;
        sel_y        = req_i.side_b;
        sel_z        = req_i.side_c;
      end
    end
  end

  // stage 1 to 3: select, squares, sums
  logic             s1_v_q, s2_v_q, s3_v_q;
  meta_t            s1_meta_q, s2_meta_q, s3_meta_q;
  logic [SideW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [AngW-1:0]  s1_deg_q;
  logic [SqrW-1:0]  s2_xx_q, s2_yy_q, s2_zz_q, s2_xy_q;
  logic [RadW-1:0]  s2_rad_q;
  logic [40:0]      rad_full;
  logic [SumW-1:0]  s3_s_q, s3_d_q;
  logic [SqrW-1:0]  s3_zz_q;
  logic signed [CordW-1:0] s3_z0_q;
  logic             s3_cneg_q;
  logic signed [CordW-1:0] rad_s;

  assign rad_full = 41'(s1_deg_q) * 41'(DegToRad) + 41'd128;
  assign rad_s    = $signed(CordW'(s2_rad_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= sel_meta;
      s1_x_q    <= sel_x;
      s1_y_q    <= sel_y;
      s1_z_q    <= sel_z;
      s1_deg_q  <= sel_deg;
      s2_meta_q <= s1_meta_q;
      s2_xx_q   <= SqrW'(s1_x_q) * SqrW'(s1_x_q);
      s2_yy_q   <= SqrW'(s1_y_q) * SqrW'(s1_y_q);
      s2_zz_q   <= SqrW'(s1_z_q) * SqrW'(s1_z_q);
      s2_xy_q   <= SqrW'(s1_x_q) * SqrW'(s1_y_q);
      s2_rad_q  <= rad_full[40:8];
      s3_meta_q <= s2_meta_q;
      s3_s_q    <= SumW'(s2_xx_q) + SumW'(s2_yy_q);
      s3_d_q    <= {s2_xy_q, 1'b0};
      s3_zz_q   <= s2_zz_q;
      s3_cneg_q <= rad_s > HalfPiQ30;
      s3_z0_q   <= (rad_s > HalfPiQ30) ? PiQ30 - rad_s : rad_s;
    end
  end

  // cosine
  rot_t                    rot_in, rot_out;
  logic [$bits(rot_t)-1:0] rot_tag;
  logic                    rot_v;
  logic signed [CordW-1:0] rot_x;

  assign rot_in = '{meta: s3_meta_q, s: s3_s_q, d: s3_d_q, zz: s3_zz_q, cneg: s3_cneg_q};

  lcs_cordic #(
    .Iter      (Iter),
    .Vectoring (1'b0),
    .TagW      ($bits(rot_t))
  ) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_v_q),
    .x_i     (GainQ30),
    .y_i     ('0),
    .z_i     (s3_z0_q),
    .tag_i   (rot_in),
    .valid_o (rot_v),
    .x_o     (rot_x),
    .y_o     (),
    .z_o     (),
    .tag_o   (rot_tag)
  );

  assign rot_out = rot_t'(rot_tag);

  // scaled cosine term and angle numerator
  logic signed [CordW-1:0] xc;
  logic [CordW-1:0]        xc_mag;
  logic                    m1_v_q;
  meta_t                   m1_meta_q;
  logic [SumW-1:0]         m1_s_q, m1_d_q, m1_mag_q;
  logic                    m1_csgn_q, m1_neg_q;
  logic [63:0]             m1_pa_q, m1_pb_q;
  logic                    neg_d;

  always_comb begin
    if (rot_x > OneQ30) begin
      xc = OneQ30;
    end else if (rot_x < NegOneQ30) begin
      xc = NegOneQ30;
    end else begin
      xc = rot_x;
    end
  end

  assign xc_mag = xc[CordW-1] ? CordW'(-xc) : CordW'(xc);
  assign neg_d  = rot_out.s < SumW'(rot_out.zz);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_meta_q <= rot_out.meta;
      m1_s_q    <= rot_out.s;
      m1_d_q    <= rot_out.d;
      m1_csgn_q <= rot_out.cneg ^ xc[CordW-1];
      m1_pa_q   <= 64'(rot_out.d) * 64'(xc_mag[30:15]);
      m1_pb_q   <= 64'(rot_out.d) * 64'(xc_mag[14:0]);
      m1_neg_q  <= neg_d;
      m1_mag_q  <= neg_d ? SumW'(rot_out.zz) - rot_out.s : rot_out.s - SumW'(rot_out.zz);
    end
  end

  // side radicand and divider
  logic [SumW:0]    t_lo, term;
  logic [SradW-1:0] srad;

  assign t_lo = (SumW'(1'b0) + (SumW+1)'(m1_pa_q[14:0]) + (SumW+1)'(m1_pb_q[63:15])) >> 15;
  assign term = (SumW+1)'(m1_pa_q[63:15]) + t_lo;

  always_comb begin
    if (m1_csgn_q) begin
      srad = SradW'(m1_s_q) + SradW'(term);
    end else if (SradW'(m1_s_q) > SradW'(term)) begin
      srad = SradW'(m1_s_q) - SradW'(term);
    end else begin
      srad = '0;
    end
  end

  logic             dv_v_q   [QFrac+1];
  div_t             dv_tag_q [QFrac+1];
  logic [SumW-1:0]  dv_r_q   [QFrac+1];
  logic [SumW-1:0]  dv_d_q   [QFrac+1];
  logic [QFrac-1:0] dv_q_q   [QFrac+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_tag_q[0] <= '{meta: m1_meta_q, neg: m1_neg_q, bad: m1_mag_q > m1_d_q,
                       eq: m1_mag_q == m1_d_q, srad: srad};
      dv_r_q[0]   <= m1_mag_q;
      dv_d_q[0]   <= m1_d_q;
      dv_q_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QFrac; k++) begin : g_div
    logic [SumW:0] r2, diff;
    logic          ge;

    assign r2   = {dv_r_q[k], 1'b0};
    assign diff = r2 - {1'b0, dv_d_q[k]};
    assign ge   = r2 >= {1'b0, dv_d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_tag_q[k+1] <= dv_tag_q[k];
        dv_r_q[k+1]   <= ge ? diff[SumW-1:0] : r2[SumW-1:0];
        dv_d_q[k+1]   <= dv_d_q[k];
        dv_q_q[k+1]   <= {dv_q_q[k][QFrac-2:0], ge};
      end
    end
  end

  // quotient square and shared square root
  div_t             dq;
  logic [QFrac:0]   qf;
  logic [SqW-1:0]   qsq;
  logic             q_v_q;
  logic [SqW-1:0]   q_rad_q;
  sq_t              q_tag_q;

  assign dq  = dv_tag_q[QFrac];
  assign qf  = dq.eq ? (QFrac+1)'(1) << QFrac : {1'b0, dv_q_q[QFrac]};
  assign qsq = SqW'(qf) * SqW'(qf);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_rad_q <= (dq.meta.kind == KIND_SIDE) ? SqW'(dq.srad) : (SqW'(1) << 60) - qsq;
      q_tag_q <= '{meta: dq.meta, neg: dq.neg, bad: dq.bad, q: qf};
    end
  end

  logic                    sq_v;
  logic [RootW-1:0]        sq_root;
  logic [$bits(sq_t)-1:0]  sq_tag;
  sq_t                     sq_out;

  lcs_isqrt #(
    .InW  (SqW),
    .TagW ($bits(sq_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (q_v_q),
    .rad_i   (q_rad_q),
    .tag_i   (q_tag_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign sq_out = sq_t'(sq_tag);

  // arccosine
  logic                    tneg;
  logic                    v_v_q;
  vec_t                    v_tag_q;
  logic signed [CordW-1:0] v_x_q, v_y_q, v_z_q;
  logic signed [CordW-1:0] root_s, q_s;

  assign tneg   = sq_out.neg && (sq_out.q != '0);
  assign root_s = $signed(CordW'(sq_root));
  assign q_s    = $signed(CordW'(sq_out.q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_tag_q <= '{meta: sq_out.meta, bad: sq_out.bad, ans: sq_root[AnsW-1:0]};
      v_x_q   <= tneg ? root_s : q_s;
      v_y_q   <= tneg ? q_s : root_s;
      v_z_q   <= tneg ? HalfPiQ30 : '0;
    end
  end

  logic                    vc_v;
  logic signed [CordW-1:0] vc_z;
  logic [$bits(vec_t)-1:0] vc_tag;

  lcs_cordic #(
    .Iter      (Iter),
    .Vectoring (1'b1),
    .TagW      ($bits(vec_t))
  ) u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_v_q),
    .x_i     (v_x_q),
    .y_i     (v_y_q),
    .z_i     (v_z_q),
    .tag_i   (v_tag_q),
    .valid_o (vc_v),
    .x_o     (),
    .y_o     (),
    .z_o     (vc_z),
    .tag_o   (vc_tag)
  );

  // radians to degrees
  logic signed [CordW-1:0] acc_c;
  logic                    r_v_q;
  vec_t                    r_tag_q;
  logic [SqW-1:0]          r_prod_q;

  always_comb begin
    if (vc_z[CordW-1]) begin
      acc_c = '0;
    end else if (vc_z > PiQ30) begin
      acc_c = PiQ30;
    end else begin
      acc_c = vc_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_tag_q  <= vec_t'(vc_tag);
      r_prod_q <= SqW'(acc_c[31:0]) * SqW'(RadToDeg);
    end
  end

  // output register
  logic [SqW-1:0]   deg_sh;
  logic [AngW-1:0]  deg;
  logic [AnsW-1:0]  out_ans_d, out_ans_q;
  status_e          out_stat_d, out_stat_q;
  logic [IdxW-1:0]  out_idx_q;

  assign deg_sh = (r_prod_q + (SqW'(1) << 45)) >> 46;
  assign deg    = (deg_sh > SqW'(Deg180)) ? Deg180 : deg_sh[AngW-1:0];

  always_comb begin
    case (r_tag_q.meta.kind)
      KIND_SIDE: begin
        out_ans_d  = r_tag_q.ans;
        out_stat_d = STATUS_SIDE;
      end
      KIND_ANGLE: begin
        out_ans_d  = r_tag_q.bad ? '0 : AnsW'(deg);
        out_stat_d = r_tag_q.bad ? STATUS_NOTRI : STATUS_ANGLE;
      end
      default: begin
        out_ans_d  = '0;
        out_stat_d = STATUS_NOFIT;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ans_q  <= out_ans_d;
      out_stat_q <= out_stat_d;
      out_idx_q  <= r_tag_q.meta.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      m1_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
      q_v_q     <= 1'b0;
      v_v_q     <= 1'b0;
      r_v_q     <= 1'b0;
      out_v_q   <= 1'b0;
    end else if (adv) begin
      s1_v_q    <= req_i.valid;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      m1_v_q    <= rot_v;
      dv_v_q[0] <= m1_v_q;
      q_v_q     <= dv_v_q[QFrac];
      v_v_q     <= sq_v;
      r_v_q     <= vc_v;
      out_v_q   <= r_v_q;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.answer       = out_ans_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.solved_index = out_idx_q;

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && adv |=> s1_v_q)
    else $error("accepted transfer did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(r_v_q) && $stable(out_v_q))
    else $error("pipeline moved during a stall");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stat_q == STATUS_NOFIT |-> out_ans_q == '0 && out_idx_q == '0)
    else $error("no-fit result carries data");

  a_notri_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stat_q == STATUS_NOTRI |-> out_ans_q == '0)
    else $error("non-triangle result carries data");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stat_q == STATUS_ANGLE |-> out_ans_q <= AnsW'(Deg180))
    else $error("solved angle above half turn");

endmodule
